### rtl/sps_pkg.sv
package sps_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register addresses (byte)
   localparam logic [CSR_ADDR_W-1:0] ADDR_ACTIVE_SLOTS = 3'd0;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // runner codes: 0..255 process number, plus idle and no-previous-segment
   localparam logic [8:0] RUNNER_IDLE = 9'd256;
   localparam logic [8:0] RUNNER_NONE = 9'd511;

   typedef struct packed {
      logic [0:0]  opcode;
      logic [3:0]  slot;
      logic [7:0]  proc_id;
      logic [15:0] arrival;
      logic [15:0] burst;
   } req_type;

   typedef struct packed {
      logic [15:0] tick_time;
      logic        idle;
      logic [7:0]  running_id;
      logic        new_segment;
      logic        finished;
      logic        all_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  proc_id;
      logic [15:0] arrival;
      logic [15:0] remaining;
   } slot_entry_type;

   typedef struct packed {
      logic clear;
      logic cmp_en;
   } scan_ctl_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  best_id;
      logic [15:0] best_arr;
      logic [15:0] best_rem;
      logic        done;
   } scan_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

endpackage

### rtl/sps_csr.sv
module sps_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sps_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sps_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sps_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready,
   output logic [4:0]                           active_slots
);
   import sps_pkg::*;

   logic [4:0] active_ff;
   logic [4:0] active_in;
   logic       sel_active;

   // one register: decode on the word address only
   assign sel_active = (csr_paddr[CSR_ADDR_W-1:2] == ADDR_ACTIVE_SLOTS[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      active_in = active_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_active) begin
         active_in = csr_pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign csr_prdata   = sel_active ? CSR_DATA_W'(active_ff) : '0;
   assign active_slots = active_ff;

endmodule

### rtl/sps_slot_mem.sv
module sps_slot_mem #(
   parameter int SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(SLOTS)-1:0]     wr_addr,
   input  sps_pkg::slot_entry_type      wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(SLOTS)-1:0]     rd_addr,
   output sps_pkg::slot_entry_type      rd_data,
   output logic                         rd_valid
);
   import sps_pkg::*;

   slot_entry_type mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   slot_entry_type   rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // an entry never written reads back with rd_valid low, which the scan treats as zero remaining work
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

### rtl/sps_scan.sv
module sps_scan #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sps_pkg::scan_ctl_type        ctl,
   input  logic [$clog2(SLOTS)-1:0]     cmp_idx,
   input  sps_pkg::slot_entry_type      entry,
   input  logic                         entry_valid,
   input  logic [TIME_BITS-1:0]         time_now,
   input  logic                         cur_valid,
   input  logic [$clog2(SLOTS)-1:0]     cur_slot,
   output sps_pkg::scan_res_type        res,
   output logic [$clog2(SLOTS)-1:0]     best_idx
);
   import sps_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

   logic             found_ff, found_in;
   logic             multi_ff, multi_in;
   logic             other_ff, other_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [7:0]       best_id_ff, best_id_in;
   logic [15:0]      best_arr_ff, best_arr_in;
   logic [15:0]      best_rem_ff, best_rem_in;

   logic [15:0]      rem;
   logic             arrived;
   logic             cand;
   logic             better;

   assign rem     = entry_valid ? entry.remaining : '0;
   assign arrived = (CMP_W'(entry.arrival) <= CMP_W'(time_now));
   assign cand    = (rem != '0) && arrived;

   // slots come in ascending order, so a full tie keeps the earlier one
   // unless the newcomer is the incumbent
   assign better = (rem < best_rem_ff) ||
                   ((rem == best_rem_ff) &&
                    ((entry.arrival < best_arr_ff) ||
                     ((entry.arrival == best_arr_ff) && cur_valid && (cmp_idx == cur_slot))));

   always_comb begin
      found_in    = found_ff;
      multi_in    = multi_ff;
      other_in    = other_ff;
      best_idx_in = best_idx_ff;
      best_id_in  = best_id_ff;
      best_arr_in = best_arr_ff;
      best_rem_in = best_rem_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
         multi_in = 1'b0;
         other_in = 1'b0;
      end else if (ctl.cmp_en) begin
         if ((rem != '0) && !arrived) begin
            other_in = 1'b1;
         end
         if (cand) begin
            if (found_ff) begin
               multi_in = 1'b1;
            end
            if (!found_ff || better) begin
               found_in    = 1'b1;
               best_idx_in = cmp_idx;
               best_id_in  = entry.proc_id;
               best_arr_in = entry.arrival;
               best_rem_in = rem;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         multi_ff <= 1'b0;
         other_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
         multi_ff <= multi_in;
         other_ff <= other_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_id_ff  <= best_id_in;
      best_arr_ff <= best_arr_in;
      best_rem_ff <= best_rem_in;
   end

   assign res.found    = found_ff;
   assign res.best_id  = best_id_ff;
   assign res.best_arr = best_arr_ff;
   assign res.best_rem = best_rem_ff;
   // done after the charge: nothing else holds work, and the runner used its last unit
   assign res.done     = !other_ff &&
                         (!found_ff || (!multi_ff && (best_rem_ff == 16'd1)));
   assign best_idx     = best_idx_ff;

endmodule

### rtl/srt_preemptive_scheduler_unit.sv
// Load item: accepted while idle, writes the slot entry, no result.
// Tick item: scan, drain and update states; no new item is taken until the update state
// registers the result. The slot memory is read one entry a cycle by a single comparator
// over the active slots (none: scan skipped), then the update state charges the winner.
// Reset (synchronous) clears the valid bit of every slot at once, the time, the
// incumbent and the segment history; no clearing pass is needed.
module srt_preemptive_scheduler_unit #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sps_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sps_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import sps_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic [TIME_BITS-1:0] time_now_ff, time_now_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0] cur_slot_ff, cur_slot_in;
   logic [8:0]       last_runner_ff, last_runner_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [4:0]       active_slots;
   logic [CNT_W-1:0] n_slots;
   logic             req_fire;
   logic             upd_fire;
   logic             last_issue;
   logic             load_ok;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   slot_entry_type   mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   slot_entry_type   mem_rd_data;
   logic             mem_rd_valid;

   scan_ctl_type     scan_ctl;
   scan_res_type     scan_res;
   logic [IDX_W-1:0] best_idx;
   logic [8:0]       runner;

   sps_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .active_slots (active_slots)
   );

   sps_slot_mem #(.SLOTS(SLOTS)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_data  (mem_rd_data),
      .rd_valid (mem_rd_valid)
   );

   sps_scan #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .cmp_idx     (cmp_idx_ff),
      .entry       (mem_rd_data),
      .entry_valid (mem_rd_valid),
      .time_now    (time_now_ff),
      .cur_valid   (cur_valid_ff),
      .cur_slot    (cur_slot_ff),
      .res         (scan_res),
      .best_idx    (best_idx)
   );

   always_comb begin
      if (32'(active_slots) > 32'(SLOTS)) begin
         n_slots = CNT_W'(SLOTS);
      end else begin
         n_slots = CNT_W'(active_slots);
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign upd_fire   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign last_issue = (CNT_W'(scan_cnt_ff + 1'b1) == n_slots);
   assign load_ok    = (32'(req_data.slot) < 32'(SLOTS));
   assign runner     = scan_res.found ? {1'b0, scan_res.best_id} : RUNNER_IDLE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.opcode == OP_TICK)) begin
               state_in = (n_slots == '0) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      scan_ctl.clear  = 1'b0;
      scan_ctl.cmp_en = cmp_vld_ff;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = scan_cnt_ff[IDX_W-1:0];
      mem_wr_en       = 1'b0;
      mem_wr_addr     = best_idx;
      mem_wr_data.proc_id   = scan_res.best_id;
      mem_wr_data.arrival   = scan_res.best_arr;
      mem_wr_data.remaining = scan_res.best_rem - 16'd1;
      scan_cnt_in     = scan_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (req_fire && (req_data.opcode == OP_TICK)) begin
               scan_ctl.clear = 1'b1;
            end
            if (req_fire && (req_data.opcode == OP_LOAD) && load_ok) begin
               mem_wr_en             = 1'b1;
               mem_wr_addr           = IDX_W'(req_data.slot);
               mem_wr_data.proc_id   = req_data.proc_id;
               mem_wr_data.arrival   = req_data.arrival;
               mem_wr_data.remaining = req_data.burst;
            end
         end
         ST_SCAN: begin
            mem_rd_en   = 1'b1;
            scan_cnt_in = CNT_W'(scan_cnt_ff + 1'b1);
         end
         ST_DRAIN: begin
         end
         ST_UPDATE: begin
            // charge the winner one unit
            mem_wr_en = upd_fire && scan_res.found;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.tick_time   = 16'(time_now_ff);
      rsp_data_in.idle        = !scan_res.found;
      rsp_data_in.running_id  = scan_res.found ? scan_res.best_id : '0;
      rsp_data_in.new_segment = (runner != last_runner_ff);
      rsp_data_in.finished    = scan_res.found && (scan_res.best_rem == 16'd1);
      rsp_data_in.all_done    = scan_res.done;

      rsp_valid_in   = rsp_valid_ff;
      time_now_in    = time_now_ff;
      cur_valid_in   = cur_valid_ff;
      cur_slot_in    = cur_slot_ff;
      last_runner_in = last_runner_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (upd_fire) begin
         rsp_valid_in   = 1'b1;
         last_runner_in = runner;
         if (time_now_ff != '1) begin
            time_now_in = TIME_BITS'(time_now_ff + 1'b1);
         end
         if (scan_res.found) begin
            cur_valid_in = 1'b1;
            cur_slot_in  = best_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scan_cnt_ff    <= '0;
         cmp_vld_ff     <= 1'b0;
         time_now_ff    <= '0;
         cur_valid_ff   <= 1'b0;
         cur_slot_ff    <= '0;
         last_runner_ff <= RUNNER_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_cnt_ff    <= scan_cnt_in;
         cmp_vld_ff     <= mem_rd_en;
         time_now_ff    <= time_now_in;
         cur_valid_ff   <= cur_valid_in;
         cur_slot_ff    <= cur_slot_in;
         last_runner_ff <= last_runner_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= mem_rd_addr;
      if (upd_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no write may land while the scan is still reading the memory
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !mem_wr_en)
      else $error("slot memory written during scan");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff < n_slots))
      else $error("scan address beyond active slots");

   a_winner_has_work: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && scan_res.found) |-> (scan_res.best_rem != '0))
      else $error("chosen slot has no remaining work");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      $past(upd_fire) |-> ((time_now_ff == TIME_BITS'($past(time_now_ff) + 1'b1)) ||
                           ($past(time_now_ff) == '1 && $stable(time_now_ff))))
      else $error("time counter did not advance after tick");

endmodule

### tb/tb_srt_preemptive_scheduler_unit.sv
module tb_srt_preemptive_scheduler_unit;
   import sps_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int NSLOTS        = 16;
   localparam logic [15:0] TIME_TOP = 16'hFFFF;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   srt_preemptive_scheduler_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow copy of the scheduler
   logic [4:0]  sched_active;
   logic [15:0] sched_arrival [NSLOTS];
   logic [15:0] sched_left [NSLOTS];
   logic [7:0]  sched_pid [NSLOTS];
   logic [3:0]  sched_cur;
   logic        sched_cur_ok;
   logic [8:0]  sched_last;
   logic [15:0] sched_time;

   req_type pending_items [$];
   rsp_type tick_results [$];

   logic [4:0] corner_settings [4] = '{5'd1, 5'd16, 5'd31, 5'd0};

   int  n_queued = 0;
   int  n_taken = 0;
   int  n_errors = 0;
   int  n_checked = 0;
   int  n_loads = 0;
   int  n_ticks = 0;
   int  n_idle_ticks = 0;
   int  n_finished = 0;
   int  n_all_done = 0;
   int  n_settings = 0;
   int  random_items = 0;
   int  req_gap = 0;
   int  rsp_hold = 0;
   int  quiet_cycles = 0;
   bit  idling_on = 1'b1;

   initial forever #HALF_PERIOD clock = ~clock;

   function automatic bit outranks(input int a, input int b);
      if (sched_left[a] != sched_left[b])
         return sched_left[a] < sched_left[b];
      if (sched_arrival[a] != sched_arrival[b])
         return sched_arrival[a] < sched_arrival[b];
      if (sched_cur_ok && a == sched_cur)
         return 1'b1;
      if (sched_cur_ok && b == sched_cur)
         return 1'b0;
      return a < b;
   endfunction

   task automatic schedule_item(input req_type it);
      int         n;
      int         pick;
      bit         found;
      bit         done;
      logic [8:0] runner;
      rsp_type    r;
      if (it.opcode == OP_LOAD) begin
         sched_pid[it.slot]     = it.proc_id;
         sched_arrival[it.slot] = it.arrival;
         sched_left[it.slot]    = it.burst;
         n_loads++;
         return;
      end
      n = (sched_active > NSLOTS) ? NSLOTS : int'(sched_active);
      found = 1'b0;
      pick = 0;
      for (int i = 0; i < n; i++) begin
         if (sched_left[i] != 0 && sched_arrival[i] <= sched_time &&
             (!found || outranks(i, pick))) begin
            pick = i;
            found = 1'b1;
         end
      end
      r = '0;
      r.tick_time = sched_time;
      r.idle = !found;
      runner = RUNNER_IDLE;
      if (found) begin
         sched_left[pick] = sched_left[pick] - 16'd1;
         r.finished = (sched_left[pick] == 0);
         r.running_id = sched_pid[pick];
         runner = {1'b0, sched_pid[pick]};
         sched_cur = pick[3:0];
         sched_cur_ok = 1'b1;
      end
      done = 1'b1;
      for (int i = 0; i < n; i++)
         if (sched_left[i] != 0)
            done = 1'b0;
      r.all_done = done;
      r.new_segment = (runner != sched_last);
      sched_last = runner;
      if (sched_time != TIME_TOP)
         sched_time = sched_time + 16'd1;
      tick_results.push_back(r);
      n_ticks++;
      n_idle_ticks += int'(r.idle);
      n_finished += int'(r.finished);
      n_all_done += int'(r.all_done);
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         n_errors++;
      end
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      n_checked++;
      if (tick_results.size() == 0) begin
         $error("result with no tick outstanding: %h", got);
         n_errors++;
         return;
      end
      want = tick_results.pop_front();
      compare_field("tick_time", want.tick_time, got.tick_time);
      compare_field("idle", want.idle, got.idle);
      compare_field("running_id", want.running_id, got.running_id);
      compare_field("new_segment", want.new_segment, got.new_segment);
      compare_field("finished", want.finished, got.finished);
      compare_field("all_done", want.all_done, got.all_done);
   endtask

   // driver: hold a stalled item, otherwise feed the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            schedule_item(req_data);
            n_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0 && idling_on &&
                         $urandom_range(0, 11) == 0) begin
               req_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check accepted results, stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            rsp_hold = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_load(input logic [3:0] s, input logic [7:0] pid,
                            input logic [15:0] arr, input logic [15:0] b);
      req_type it;
      it.opcode  = OP_LOAD;
      it.slot    = s;
      it.proc_id = pid;
      it.arrival = arr;
      it.burst   = b;
      pending_items.push_back(it);
      n_queued++;
   endtask

   task automatic push_tick();
      req_type     it;
      logic [63:0] junk;
      // junk in the unused fields must not matter
      junk = {$urandom, $urandom};
      it = junk[$bits(req_type)-1:0];
      it.opcode = OP_TICK;
      pending_items.push_back(it);
      n_queued++;
   endtask

   task automatic settle();
      while (n_taken != n_queued || tick_results.size() != 0)
         @(posedge clock);
      // let a trailing load finish before touching the register
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_active(input logic [4:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_ACTIVE_SLOTS;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sched_active = value;
      n_settings++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $error("active_slots readback: expected %0d, actual %0d", value, csr_prdata);
         n_errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_arrival(input int t0, input int spread);
      int a;
      if ($urandom_range(0, 7) == 0)
         return 16'($urandom);
      a = t0 + $urandom_range(0, spread);
      return (a > 65535) ? 16'hFFFF : 16'(a);
   endfunction

   function automatic logic [15:0] pick_burst();
      int r;
      r = $urandom_range(0, 39);
      if (r < 2)
         return 16'd0;
      if (r == 2)
         return 16'($urandom);
      if (r < 9)
         return 16'($urandom_range(9, 40));
      return 16'($urandom_range(1, 8));
   endfunction

   // load every active slot, then run ticks with the odd late arrival mixed in
   task automatic random_phase(input logic [4:0] setting);
      int         nuse;
      int         t0;
      int         nticks;
      int         first;
      logic [7:0] pid;
      settle();
      set_active(setting);
      idling_on = ($urandom_range(0, 3) != 0);
      first = n_queued;
      nuse = (setting > NSLOTS) ? NSLOTS : int'(setting);
      t0 = int'(sched_time);
      pid = 8'($urandom);
      for (int s = 0; s < nuse; s++) begin
         // keep the previous number now and then: duplicate process numbers
         if ($urandom_range(0, 3) != 0)
            pid = 8'($urandom);
         push_load(4'(s), pid, pick_arrival(t0, 12), pick_burst());
      end
      if (nuse < NSLOTS && $urandom_range(0, 1) == 1)
         push_load(4'($urandom_range(nuse, NSLOTS - 1)), 8'($urandom),
                   pick_arrival(t0, 4), pick_burst());
      nticks = 8 + $urandom_range(0, 6 * nuse);
      for (int k = 0; k < nticks; k++) begin
         push_tick();
         if ($urandom_range(0, 9) == 0)
            push_load(4'($urandom_range(0, NSLOTS - 1)), 8'($urandom),
                      pick_arrival(t0 + k, 4), pick_burst());
      end
      random_items += n_queued - first;
   endtask

   initial begin
      int phase;
      sched_active = '0;
      for (int i = 0; i < NSLOTS; i++) begin
         sched_arrival[i] = '0;
         sched_left[i] = '0;
         sched_pid[i] = '0;
      end
      sched_cur = '0;
      sched_cur_ok = 1'b0;
      sched_last = RUNNER_NONE;
      sched_time = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // no active slots: idle ticks, first one opens a segment
      push_tick();
      push_tick();
      settle();
      set_active(5'd4);
      push_load(4'd3, 8'h5A, 16'd0, 16'd2);
      push_tick();
      // equal remaining and arrival: incumbent in slot 3 beats slot 0
      push_load(4'd0, 8'hFF, 16'd0, 16'd1);
      push_tick();
      push_tick();
      // equal remaining, slot 1 arrived earlier; slot 2 shares number FF with slot 0
      push_load(4'd1, 8'h00, 16'd0, 16'd2);
      push_load(4'd2, 8'hFF, 16'd5, 16'd2);
      push_load(4'd0, 8'hFF, 16'hFFFF, 16'hFFFF);
      push_load(4'd4, 8'h11, 16'd0, 16'd1);
      push_load(4'd3, 8'h22, 16'd0, 16'd0);
      repeat (6) push_tick();

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase < 4)
            random_phase(corner_settings[phase]);
         else if ($urandom_range(0, 5) == 0)
            random_phase(5'($urandom));
         else
            random_phase(5'($urandom_range(1, NSLOTS)));
         phase++;
      end

      // fill every slot and run the work down, no idling from here on
      settle();
      idling_on = 1'b0;
      set_active(5'd16);
      for (int s = 0; s < NSLOTS; s++) begin
         push_load(4'(s), 8'($urandom), pick_arrival(int'(sched_time), 8),
                   16'($urandom_range(1, 4)));
      end
      repeat (NSLOTS * 4 + 4) push_tick();
      settle();

      if (tick_results.size() != 0)
         n_errors++;
      $display("covered %0d loads and %0d ticks (%0d idle, %0d completions, %0d all-done)",
               n_loads, n_ticks, n_idle_ticks, n_finished, n_all_done);
      $display("%0d results compared over %0d register settings, clock ended at %0d",
               n_checked, n_settings, sched_time);
      if (n_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
